// ===== src/bba_pkg.sv =====
// Package for the bitmap block allocator: opcodes, status codes, FSM states
// and the fixed widths shared by the design. No dependencies.

package bba_pkg;

   // Fixed field widths
   localparam int OPCODE_W    = 3;
   localparam int INDEX_W     = 12;
   localparam int STATUS_W    = 2;
   localparam int POS_W       = 13;            // capacity, hint, count, block positions
   localparam int WORD_BITS   = 64;            // bitmap word width
   localparam int BIT_W       = 6;             // bit offset inside a word
   localparam int WPTR_W      = POS_W - BIT_W; // word number of a position
   localparam int DATA_W      = 32;            // APB data width
   localparam int ADDR_W_CSR  = 3;             // APB byte address width

   localparam int MAX_BLOCKS_DEF = 4096;
   localparam int CAP_MAX        = (1 << POS_W) - 1;
   localparam logic [POS_W-1:0] CAP_RESET = POS_W'(4096);

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC     = 3'd0,
      OP_FREE      = 3'd1,
      OP_NEXT_LIN  = 3'd2,
      OP_NEXT_CIRC = 3'd3,
      OP_QUERY     = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_OOM      = 2'd1,
      STAT_BAD_FREE = 2'd2,
      STAT_END      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LAUNCH,
      S_SCAN,
      S_CHECK
   } state_type;

   // Register index of block_capacity
   localparam logic REG_CAPACITY = 1'b0;

endpackage

// ===== src/bitmap_block_allocator.sv =====
// Bitmap block allocator top level: bitmap memory, scan sequencer and CSR.
// Depends on bba_pkg.

// Fixed-size block allocator. One used bit per block is held in a memory of
// 64-bit words (MAX_BLOCKS/64 words, rounded up) with a registered read port.
// A transaction is accepted when start is high and busy is low. Its result is
// shown on the rsp_ ports for exactly one cycle with rsp_valid high and cannot
// be held off. Free and query do one word read and check. Unknown opcodes and
// a circular iterator with a zero count are answered without a read. Allocate
// and the linear iterator read bitmap words one word per cycle with a
// find-first-set until a match or the end of the range. The circular iterator
// scans from its start to the capacity and then from zero to its start, with
// one relaunch between the two ranges. busy drops in the cycle the result is
// shown, so the next transaction can be accepted in that cycle. After reset
// the block clears the bitmap one word a cycle and holds busy high meanwhile;
// the APB port is served throughout. block_capacity lies at APB byte address 0.

module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic [bba_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [bba_pkg::INDEX_W-1:0]       req_block_index,
   input  logic                              req_from_start,
   // result channel
   output logic                              rsp_valid,
   output logic [bba_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bba_pkg::INDEX_W-1:0]       rsp_result_index,
   output logic                              rsp_is_used,
   output logic [bba_pkg::POS_W-1:0]         rsp_live_count,
   // APB configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bba_pkg::ADDR_W_CSR-1:0]    paddr,
   input  logic [bba_pkg::DATA_W-1:0]        pwdata,
   output logic [bba_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   import bba_pkg::*;

   localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CAP_LIM    = (MAX_BLOCKS > CAP_MAX) ? CAP_MAX : MAX_BLOCKS;
   localparam logic [POS_W-1:0] CAP_LIM_V  = POS_W'(CAP_LIM);
   localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(WORD_COUNT - 1);
   localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type               state_ff, state_in;
   logic [POS_W-1:0]        cap_cfg_ff, cap_cfg_in;
   logic [POS_W-1:0]        hint_ff, hint_in;
   logic [POS_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       clr_ptr_ff, clr_ptr_in;

   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [INDEX_W-1:0]      idx_ff, idx_in;
   logic                    fs_ff, fs_in;
   logic                    phase_ff, phase_in;
   logic [POS_W-1:0]        lo_ff, lo_in;
   logic [POS_W-1:0]        hi_ff, hi_in;
   logic [POS_W-1:0]        wstart_ff, wstart_in;
   logic [WPTR_W-1:0]       wptr_ff, wptr_in;
   logic                    first_ff, first_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                    rsp_used_ff, rsp_used_in;
   logic [POS_W-1:0]        rsp_count_ff, rsp_count_in;

   // bitmap memory
   logic [WORD_BITS-1:0]    bitmap_mem [WORD_COUNT];
   logic [WORD_BITS-1:0]    rd_data_ff;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [WORD_BITS-1:0]    wr_data;

   // ---------------------------------------------------------------------
   // Scan datapath
   // ---------------------------------------------------------------------
   logic [POS_W-1:0]        cap;
   logic [POS_W-1:0]        start_lin;
   logic [POS_W-1:0]        start_circ;
   logic [POS_W-1:0]        lo_c, hi_c;
   logic                    want_used;
   logic [WORD_BITS-1:0]    lo_mask, hi_mask, cand;
   logic                    found;
   logic [BIT_W-1:0]        ffs;
   logic [POS_W-1:0]        found_pos;
   logic [WPTR_W:0]         wptr_next;
   logic                    range_done;
   logic                    chk_bit;
   logic                    chk_in_range;

   // effective capacity
   assign cap = (cap_cfg_ff > CAP_LIM_V) ? CAP_LIM_V : cap_cfg_ff;

   // iterator start positions
   assign start_lin  = fs_ff ? '0 : ({1'b0, idx_ff} + POS_W'(1));
   assign start_circ = (start_lin >= cap) ? '0 : start_lin;

   assign want_used = (op_ff != OP_ALLOC);

   // masks for the word under evaluation
   assign lo_mask = first_ff ? (ALL_ONES << lo_ff[BIT_W-1:0]) : ALL_ONES;
   assign hi_mask = (wptr_ff == hi_ff[POS_W-1:BIT_W])
                    ? ((WORD_BITS'(1) << hi_ff[BIT_W-1:0]) - WORD_BITS'(1))
                    : ALL_ONES;
   assign cand    = (want_used ? rd_data_ff : ~rd_data_ff) & lo_mask & hi_mask;
   assign found   = |cand;

   // find first set bit
   always_comb begin
      ffs = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (cand[j]) begin
            ffs = BIT_W'(j);
         end
      end
   end

   assign found_pos  = {wptr_ff, ffs};
   assign wptr_next  = {1'b0, wptr_ff} + (WPTR_W+1)'(1);
   assign range_done = ({wptr_next, {BIT_W{1'b0}}} >= {1'b0, hi_ff});

   // free / query bit check
   assign chk_bit      = rd_data_ff[idx_ff[BIT_W-1:0]];
   assign chk_in_range = ({1'b0, idx_ff} < cap);

   // ---------------------------------------------------------------------
   // Sequencer: next state, memory control and results
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      hint_in       = hint_ff;
      count_in      = count_ff;
      clr_ptr_in    = clr_ptr_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      fs_in         = fs_ff;
      phase_in      = phase_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      wstart_in     = wstart_ff;
      wptr_in       = wptr_ff;
      first_in      = first_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      lo_c          = '0;
      hi_c          = cap;

      case (state_ff)
         // clear bitmap after reset
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_ff;
            wr_data = '0;
            clr_ptr_in = clr_ptr_ff + ADDR_W'(1);
            if (clr_ptr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               idx_in   = req_block_index;
               fs_in    = req_from_start;
               phase_in = 1'b0;
               state_in = S_LAUNCH;
            end
         end

         // set up a scan range or a single word read, or answer at once
         S_LAUNCH: begin
            rsp_status_in = STAT_OK;
            rsp_index_in  = '0;
            rsp_used_in   = 1'b0;
            rsp_count_in  = count_ff;
            case (opcode_type'(op_ff))
               OP_ALLOC: begin
                  lo_c = hint_ff;
                  hi_c = cap;
               end
               OP_NEXT_LIN: begin
                  lo_c = start_lin;
                  hi_c = cap;
               end
               OP_NEXT_CIRC: begin
                  lo_c = phase_ff ? '0 : start_circ;
                  hi_c = phase_ff ? wstart_ff : cap;
               end
               default: begin
                  lo_c = '0;
                  hi_c = cap;
               end
            endcase

            case (opcode_type'(op_ff))
               OP_ALLOC, OP_NEXT_LIN, OP_NEXT_CIRC: begin
                  if (op_ff == OP_NEXT_CIRC && !phase_ff) begin
                     wstart_in = start_circ;
                  end
                  if (op_ff == OP_NEXT_CIRC && count_ff == '0) begin
                     rsp_status_in = STAT_END;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else if (lo_c >= hi_c) begin
                     // empty range
                     if (op_ff == OP_NEXT_CIRC && !phase_ff) begin
                        phase_in = 1'b1;
                     end else begin
                        rsp_status_in = (op_ff == OP_ALLOC) ? STAT_OOM : STAT_END;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     lo_in    = lo_c;
                     hi_in    = hi_c;
                     wptr_in  = lo_c[POS_W-1:BIT_W];
                     first_in = 1'b1;
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(lo_c[POS_W-1:BIT_W]);
                     state_in = S_SCAN;
                  end
               end
               OP_FREE, OP_QUERY: begin
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(idx_ff[INDEX_W-1:BIT_W]);
                  state_in = S_CHECK;
               end
               default: begin
                  // unknown opcode: no change
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end

         // one bitmap word per cycle; next word read issued ahead
         S_SCAN: begin
            if (found) begin
               rsp_status_in = STAT_OK;
               rsp_index_in  = found_pos[INDEX_W-1:0];
               if (op_ff == OP_ALLOC) begin
                  wr_en    = 1'b1;
                  wr_addr  = ADDR_W'(wptr_ff);
                  wr_data  = rd_data_ff | (WORD_BITS'(1) << ffs);
                  count_in = count_ff + POS_W'(1);
                  hint_in  = found_pos + POS_W'(1);
               end
               rsp_count_in = count_in;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (range_done) begin
               if (op_ff == OP_NEXT_CIRC && !phase_ff) begin
                  phase_in = 1'b1;
                  state_in = S_LAUNCH;
               end else begin
                  rsp_status_in = (op_ff == OP_ALLOC) ? STAT_OOM : STAT_END;
                  rsp_index_in  = '0;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               wptr_in  = wptr_next[WPTR_W-1:0];
               first_in = 1'b0;
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(wptr_next[WPTR_W-1:0]);
            end
         end

         // free or query on one word
         S_CHECK: begin
            if (op_ff == OP_FREE) begin
               if (chk_in_range && chk_bit) begin
                  wr_en    = 1'b1;
                  wr_addr  = ADDR_W'(idx_ff[INDEX_W-1:BIT_W]);
                  wr_data  = rd_data_ff & ~(WORD_BITS'(1) << idx_ff[BIT_W-1:0]);
                  count_in = count_ff - POS_W'(1);
                  hint_in  = '0;
                  rsp_status_in = STAT_OK;
               end else begin
                  rsp_status_in = STAT_BAD_FREE;
               end
            end else begin
               rsp_used_in = chk_in_range & chk_bit;
            end
            rsp_count_in = count_in;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Bitmap memory: one write port, one registered read port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bitmap_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // APB register write
   // ---------------------------------------------------------------------
   always_comb begin
      cap_cfg_in = cap_cfg_ff;
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
         cap_cfg_in = pwdata[POS_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_cfg_ff) : '0;

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cap_cfg_ff   <= CAP_RESET;
         hint_ff      <= '0;
         count_ff     <= '0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_cfg_ff   <= cap_cfg_in;
         hint_ff      <= hint_in;
         count_ff     <= count_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      fs_ff         <= fs_in;
      phase_ff      <= phase_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      wstart_ff     <= wstart_in;
      wptr_ff       <= wptr_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // outputs
   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_is_used      = rsp_used_ff;
   assign rsp_live_count   = rsp_count_ff;

endmodule
